// ===== src/lshbc_pkg.sv =====
// Package for the bucket compaction block: request codes, register indexes, queue entry type.
// No dependencies.
`timescale 1ns / 1ps
package lshbc_pkg;
  localparam logic [2:0] REQ_WEIGHT = 3'd0;
  localparam logic [2:0] REQ_FEAT   = 3'd1;
  localparam logic [2:0] REQ_FINISH = 3'd2;
  localparam logic [2:0] REQ_QUERY  = 3'd3;
  localparam logic [2:0] REQ_CLEAR  = 3'd4;

  localparam logic KIND_COUNT = 1'b0;
  localparam logic KIND_ID    = 1'b1;

  // configuration register indexes
  localparam logic CFG_HASH_BITS  = 1'b0;
  localparam logic CFG_FEAT_COUNT = 1'b1;

  localparam int MAX_PROJECTIONS = 10;
  localparam int MAX_FEATURES    = 128;
  localparam int NUM_BUCKETS     = 1024;

  localparam int SUM_W = 40;

  typedef struct packed {
    logic [2:0]  req;
    logic [9:0]  row;
    logic [6:0]  feat;
    logic [3:0]  proj;
    logic [15:0] sample;
  } item_t;
endpackage

// ===== src/lsh_bucket_compaction.sv =====
// Top level of the sign-hash bucket compaction block.
// Depends on lshbc_pkg, lshbc_front, lshbc_back.
//
// Usage:
//   Input channel in_valid/in_ready carries one request word: weight write,
//   feature element, finish, query or clear. Output channel out_valid/
//   out_ready carries one result word for finish (active bucket count) and
//   for query (1-based compact id of a row).
//   Configuration: cfg_we, cfg_index, cfg_data; write only while idle.
// Sequence (back part, from taking the word):
//   A two-entry queue sits between the front (accept, filter) and the back;
//   an accepted word is registered in the queue until the back takes it.
//   Weight write: written from the idle state. Feature element: MAC state,
//   plus a close state on the row's last element (10 parallel MAC lanes, one
//   weight read per lane). Finish: a sweep over the occupancy memory writing
//   the rank memory, then the count word loads once the result register is
//   free. Query: signature, then rank read. Clear: 1024-entry clearing pass.
// Reset: clears control and sums, then runs the clearing pass.
// Stall: the back holds while its result register is full and not taken;
//   the front keeps accepting until the queue fills.
`timescale 1ns / 1ps
module lsh_bucket_compaction (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  req_type,
  input  logic [9:0]  row_index,
  input  logic [6:0]  feature_index,
  input  logic [3:0]  projection_index,
  input  logic signed [15:0] sample_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        result_kind,
  output logic [9:0]  result_row,
  output logic [10:0] result_value
);
  import lshbc_pkg::*;

  logic [3:0] hash_bits;
  logic [7:0] feature_count;
  logic [3:0] hb_use;
  logic [7:0] fc_use;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      hash_bits     <= 4'd10;
      feature_count <= 8'd128;
    end else if (cfg_we) begin
      if (cfg_index == CFG_HASH_BITS) hash_bits <= cfg_data[3:0];
      else feature_count <= cfg_data;
    end
  end

  assign hb_use = (hash_bits == 4'd0) ? 4'd1 : (hash_bits > 4'd10) ? 4'd10 : hash_bits;
  assign fc_use = (feature_count == 8'd0) ? 8'd1 :
                  (feature_count > 8'd128) ? 8'd128 : feature_count;

  item_t in_item, q_item;
  logic  q_valid, q_ready;
  assign in_item = '{req: req_type, row: row_index, feat: feature_index,
                     proj: projection_index, sample: sample_value};

  lshbc_front u_front (
    .clk, .rst, .in_valid, .in_ready, .in_item, .fc_use,
    .q_valid, .q_ready, .q_item);

  lshbc_back u_back (
    .clk, .rst, .q_valid, .q_ready, .q_item, .hb_use, .fc_use,
    .out_valid, .out_ready, .out_kind(result_kind), .out_row(result_row),
    .out_value(result_value));

  // a held result stays put while stalled
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(result_value))
    else $error("result changed under stall");
  // count result always reports row zero
  a_row0: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_kind == KIND_COUNT |-> result_row == 10'd0)
    else $error("count result with nonzero row");
endmodule

// ===== src/lshbc_ram.sv =====
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module lshbc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== src/lshbc_front.sv =====
// Front part: accepts words, drops ignored ones, queues the rest (2 entries).
// Depends on lshbc_pkg.
`timescale 1ns / 1ps
module lshbc_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  lshbc_pkg::item_t    in_item,
  input  logic [7:0]          fc_use,
  output logic                q_valid,
  input  logic                q_ready,
  output lshbc_pkg::item_t    q_item
);
  import lshbc_pkg::*;

  item_t     slot [2];
  logic      rd_ptr, wr_ptr;
  logic [1:0] cnt;
  logic      keep, push, pop;

  // words the back part would ignore never enter the queue
  always_comb begin
    keep = 1'b0;
    case (in_item.req)
      REQ_WEIGHT: keep = (in_item.proj < 4'd10);
      REQ_FEAT:   keep = ({1'b0, in_item.feat} < fc_use);
      REQ_FINISH, REQ_QUERY, REQ_CLEAR: keep = 1'b1;
      default:    keep = 1'b0;
    endcase
  end

  assign in_ready = (cnt != 2'd2);
  assign push     = in_valid && in_ready && keep;
  assign q_valid  = (cnt != 2'd0);
  assign q_item   = slot[rd_ptr];
  assign pop      = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) slot[wr_ptr] <= in_item;
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      cnt    <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

// ===== src/lshbc_back.sv =====
// Back part: weight/signature/rank/occupancy memories, MAC lanes, rank sweep, output register.
// Depends on lshbc_pkg and lshbc_ram.
`timescale 1ns / 1ps
module lshbc_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  output logic              q_ready,
  input  lshbc_pkg::item_t  q_item,
  input  logic [3:0]        hb_use,
  input  logic [7:0]        fc_use,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_kind,
  output logic [9:0]        out_row,
  output logic [10:0]       out_value
);
  import lshbc_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MAC   = 3'd1;
  localparam logic [2:0] ST_CLOSE = 3'd2;
  localparam logic [2:0] ST_SWEEP = 3'd3;
  localparam logic [2:0] ST_QSIG  = 3'd4;
  localparam logic [2:0] ST_QRANK = 3'd5;
  localparam logic [2:0] ST_CLR   = 3'd6;
  localparam logic [2:0] ST_FIN   = 3'd7;

  logic [2:0]  state;
  item_t       cur;
  logic [10:0] idx;   // sweep and clear index, sweep runs to 1024
  logic [10:0] acc;
  logic [10:0] count_hold;
  logic        occ_rdy; // query: signature read data valid

  // weight memories, one per projection lane
  logic [15:0] wdata [MAX_PROJECTIONS];
  logic signed [SUM_W-1:0] sums [MAX_PROJECTIONS];
  logic [9:0]  sig;

  genvar g;
  generate
    for (g = 0; g < MAX_PROJECTIONS; g++) begin : g_lane
      lshbc_ram #(.WIDTH(16), .DEPTH(MAX_FEATURES)) u_w (
        .clk, .we(state == ST_IDLE && q_valid && q_item.req == REQ_WEIGHT
                  && q_item.proj == 4'(g)),
        .waddr(q_item.feat), .wdata(q_item.sample),
        .raddr(q_item.feat), .rdata(wdata[g]));
    end
  endgenerate

  // signature memory
  logic       sig_we;
  logic [9:0] sig_q;
  lshbc_ram #(.WIDTH(10), .DEPTH(1024)) u_sig (
    .clk, .we(sig_we), .waddr(cur.row), .wdata(sig),
    .raddr(cur.row), .rdata(sig_q));

  // rank memory, written during the finish sweep
  logic        rk_we;
  logic [9:0]  rk_waddr;
  logic [10:0] rk_wdata, rk_q;
  lshbc_ram #(.WIDTH(11), .DEPTH(NUM_BUCKETS)) u_rank (
    .clk, .we(rk_we), .waddr(rk_waddr), .wdata(rk_wdata),
    .raddr(sig_q), .rdata(rk_q));

  // occupancy memory: marked on row close, zeroed by a clearing pass, read by the sweep
  logic       occ_we, occ_wdata, occ_q;
  logic [9:0] occ_waddr;
  lshbc_ram #(.WIDTH(1), .DEPTH(NUM_BUCKETS)) u_occ (
    .clk, .we(occ_we), .waddr(occ_waddr), .wdata(occ_wdata),
    .raddr(idx[9:0]), .rdata(occ_q));

  // signature bits, projection 0 most significant
  always_comb begin
    sig = '0;
    for (int p = 0; p < MAX_PROJECTIONS; p++) begin
      if (p < int'(hb_use))
        sig = {sig[8:0], (sums[p] > 0)};
    end
  end

  logic out_free, out_load;
  assign out_free  = !out_valid || out_ready;
  assign out_load  = (state == ST_FIN && out_free) || (state == ST_QRANK);
  assign q_ready   = (state == ST_IDLE) && out_free;
  assign sig_we    = (state == ST_CLOSE);
  assign occ_we    = (state == ST_CLOSE) || (state == ST_CLR);
  assign occ_waddr = (state == ST_CLR) ? idx[9:0] : sig;
  assign occ_wdata = (state == ST_CLOSE);

  // sweep: occupancy read data is registered, so it belongs to index minus one (sw_addr)
  logic [9:0]  sw_addr;
  logic [10:0] acc_next;
  assign sw_addr  = 10'(idx - 11'd1);
  assign acc_next = acc + {10'd0, occ_q};
  assign rk_we    = (state == ST_SWEEP) && (idx != 11'd0);
  assign rk_waddr = sw_addr;
  assign rk_wdata = acc_next;

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && q_valid && q_ready) cur <= q_item;
    // sweep bookkeeping for finish
    if (rk_we) begin
      acc <= acc_next;
      if (sw_addr == 10'((11'd1 << hb_use) - 11'd1)) count_hold <= acc_next;
    end
    if (rst) begin
      state     <= ST_CLR;
      idx       <= '0;
      out_valid <= 1'b0;
      for (int p = 0; p < MAX_PROJECTIONS; p++) sums[p] <= '0;
      occ_rdy   <= 1'b0;
    end else begin
      if (out_load) out_valid <= 1'b1;
      else if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (q_valid && q_ready) begin
            case (q_item.req)
              REQ_FEAT:   state <= ST_MAC;
              REQ_FINISH: begin state <= ST_SWEEP; idx <= '0; acc <= '0; end
              REQ_QUERY:  state <= ST_QSIG;
              REQ_CLEAR:  begin state <= ST_CLR; idx <= '0; end
              default:    state <= ST_IDLE;
            endcase
          end
        end
        ST_MAC: begin
          // one multiply per lane below hb_use, weight read data now valid
          for (int p = 0; p < MAX_PROJECTIONS; p++) begin
            if (p < int'(hb_use))
              sums[p] <= sums[p] + SUM_W'($signed(wdata[p]) * $signed(cur.sample));
          end
          state <= ({1'b0, cur.feat} == fc_use - 8'd1) ? ST_CLOSE : ST_IDLE;
        end
        ST_CLOSE: begin
          for (int p = 0; p < MAX_PROJECTIONS; p++) sums[p] <= '0;
          state <= ST_IDLE;
        end
        ST_SWEEP: begin
          if (idx[10]) state <= ST_FIN;
          else idx <= idx + 11'd1;
        end
        ST_FIN: begin
          if (out_free) begin
            out_kind  <= KIND_COUNT;
            out_row   <= '0;
            out_value <= count_hold;
            state     <= ST_IDLE;
          end
        end
        ST_QSIG: begin
          occ_rdy <= occ_rdy ^ 1'b1;
          if (occ_rdy) state <= ST_QRANK;
        end
        ST_QRANK: begin
          occ_rdy   <= 1'b0;
          out_kind  <= KIND_ID;
          out_row   <= cur.row;
          out_value <= rk_q;
          state     <= ST_IDLE;
        end
        ST_CLR: begin
          // clearing pass, one occupancy entry per cycle
          if (idx[9:0] == 10'(NUM_BUCKETS - 1)) state <= ST_IDLE;
          idx <= idx + 11'd1;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end
endmodule
